// ===== rtl/core/integer_to_ascii_radix_core_defines.svh =====
// Assertion macros for the integer to ASCII radix converter checkers.
`ifndef INTEGER_TO_ASCII_RADIX_CORE_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define ITOA_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define ITOA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/itoa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and helpers of the integer to ASCII radix converter.
package itoa_pkg;

   localparam int VALUE_W    = 64;
   localparam int POS_W      = $clog2(VALUE_W);
   localparam int DIGS_W     = 80;   // twenty BCD digits, enough for 2^64-1
   localparam int NDIGS      = DIGS_W / 4;
   localparam int DAB_BITS   = 4;    // binary bits folded into BCD per cycle
   localparam int CNT_W      = 7;
   localparam int SHAMT_W    = 7;
   localparam int ITER_W     = 5;
   localparam int CHAR_W     = 7;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic CSR_IDX_BASE = 1'b0;

   localparam logic [1:0] WSEL_16 = 2'd0;
   localparam logic [1:0] WSEL_32 = 2'd1;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;
   localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'h41;
   localparam logic [CHAR_W-1:0] CHAR_HEX_F = 7'h46;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

   typedef enum logic [1:0] {
      BASE_BIN = 2'd0,
      BASE_OCT = 2'd1,
      BASE_DEC = 2'd2,
      BASE_HEX = 2'd3
   } base_type;

   localparam base_type BASE_RESET = BASE_DEC;

   typedef struct packed {
      logic load;
      logic dabble;
      logic align;
      logic skip;
      logic emit_sign;
      logic emit_digit;
   } itoa_cmd_type;

   typedef struct packed {
      logic is_dec;
      logic neg;
      logic top_zero;
      logic cnt_one;
      logic iter_last;
      logic out_free;
   } itoa_status_type;

   function automatic logic [CHAR_W-1:0] digit_glyph(input logic [3:0] d);
      logic [CHAR_W-1:0] g;
      if (d < 4'd10) begin
         g = CHAR_ZERO + {3'b000, d};
      end else begin
         g = CHAR_ALPHA + {3'b000, d - 4'd10};
      end
      return g;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/integer_to_ascii_radix_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Top level of the integer to ASCII radix converter.
//
// req_* takes one integer per transfer: tdata holds the raw bits, tuser the
// operand width code and the signed flag. rsp_* returns the characters, most
// significant first, one per transfer, with tlast on the final one. The csr_*
// port holds the radix register (binary, octal, decimal, hex).
// One number is in work at a time; req_tready is high only between numbers.
// The digit field of an operand width holds 64 binary, 22 octal, 20 decimal
// or 16 hex digits at 64 bits. The BCD pass folds 4 bits per cycle; leading
// zeros are dropped one digit per cycle, and characters go out through the
// output register one per cycle while the receiver does not stall.
// A stalled receiver holds the output register and the sequencer waits.
// Reset drops any number in work, empties the output and sets decimal radix.
module integer_to_ascii_radix_core import itoa_pkg::*; #(
   parameter int MAX_WIDTH = 64
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     csr_psel,
   input  wire                     csr_penable,
   input  wire                     csr_pwrite,
   input  wire  [CSR_ADDR_W-1:0]   csr_paddr,
   input  wire  [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  wire  [VALUE_W-1:0]      req_tdata,   // value
   input  wire  [REQ_USER_W-1:0]   req_tuser,   // width_select[1:0], is_signed
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   output logic [RSP_DATA_W-1:0]   rsp_tdata,   // ascii_char[6:0], zero pad
   output logic                    rsp_tlast
);

   itoa_cmd_type    cmd;
   itoa_status_type status;

   itoa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .status   (status),
      .cmd      (cmd)
   );

   itoa_dp #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .cmd         (cmd),
      .status      (status)
   );

endmodule
`default_nettype wire

// ===== rtl/core/itoa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sequencer of the converter: takes a number, runs BCD and align phases in decimal, then skip, sign and emit phases.
module itoa_ctrl import itoa_pkg::*; (
   input  wire             clock,
   input  wire             reset,
   input  wire             in_valid,
   output logic            in_ready,
   input  wire  itoa_status_type status,
   output itoa_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DABBLE,
      S_ALIGN,
      S_SKIP,
      S_SIGN,
      S_DIGITS
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (in_valid && ready_ff) begin
               cmd.load = 1'b1;
               state_in = status.is_dec ? S_DABBLE : S_SKIP;
            end
         end
         S_DABBLE: begin
            cmd.dabble = 1'b1;
            if (status.iter_last) begin
               state_in = S_ALIGN;
            end
         end
         S_ALIGN: begin
            cmd.align = 1'b1;
            state_in  = S_SKIP;
         end
         S_SKIP: begin
            // drop leading zero digits, but always keep the last one
            if (status.top_zero && !status.cnt_one) begin
               cmd.skip = 1'b1;
            end else begin
               state_in = status.neg ? S_SIGN : S_DIGITS;
            end
         end
         S_SIGN: begin
            if (status.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = S_DIGITS;
            end
         end
         S_DIGITS: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               if (status.cnt_one) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_IDLE);
      end
   end

   assign in_ready = ready_ff;

endmodule
`default_nettype wire

// ===== rtl/core/itoa_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Datapath of the converter: base register, digit shifter, BCD unit, output register.
module itoa_dp import itoa_pkg::*; #(
   parameter int MAX_WIDTH = 64
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     csr_psel,
   input  wire                     csr_penable,
   input  wire                     csr_pwrite,
   input  wire  [CSR_ADDR_W-1:0]   csr_paddr,
   input  wire  [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready,
   input  wire  [VALUE_W-1:0]      req_tdata,
   input  wire  [REQ_USER_W-1:0]   req_tuser,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   output logic                    rsp_tlast,
   input  wire  itoa_cmd_type      cmd,
   output itoa_status_type         status
);

   // operand widths after the MAX_WIDTH limit
   localparam int EW0 = (MAX_WIDTH < 16) ? MAX_WIDTH : 16;
   localparam int EW1 = (MAX_WIDTH < 32) ? MAX_WIDTH : 32;
   localparam int EW2 = (MAX_WIDTH < VALUE_W) ? MAX_WIDTH : VALUE_W;

   localparam logic [VALUE_W-1:0] MASK0 = (EW0 >= VALUE_W) ? {VALUE_W{1'b1}} :
                                          ((VALUE_W'(1) << EW0) - VALUE_W'(1));
   localparam logic [VALUE_W-1:0] MASK1 = (EW1 >= VALUE_W) ? {VALUE_W{1'b1}} :
                                          ((VALUE_W'(1) << EW1) - VALUE_W'(1));
   localparam logic [VALUE_W-1:0] MASK2 = (EW2 >= VALUE_W) ? {VALUE_W{1'b1}} :
                                          ((VALUE_W'(1) << EW2) - VALUE_W'(1));

   // digit counts per base
   localparam int OCT0 = (EW0 + 2) / 3;
   localparam int OCT1 = (EW1 + 2) / 3;
   localparam int OCT2 = (EW2 + 2) / 3;
   localparam int HEX0 = (EW0 + 3) / 4;
   localparam int HEX1 = (EW1 + 3) / 4;
   localparam int HEX2 = (EW2 + 3) / 4;
   localparam int DEC0 = (EW0 * 1233) / 4096 + 1;
   localparam int DEC1 = (EW1 * 1233) / 4096 + 1;
   localparam int DEC2 = (EW2 * 1233) / 4096 + 1;

   // left shifts that put the top digit at the top of the digit register
   localparam int BSH0 = DIGS_W - EW0;
   localparam int BSH1 = DIGS_W - EW1;
   localparam int BSH2 = DIGS_W - EW2;
   localparam int OSH0 = DIGS_W - 3 * OCT0;
   localparam int OSH1 = DIGS_W - 3 * OCT1;
   localparam int OSH2 = DIGS_W - 3 * OCT2;
   localparam int HSH0 = DIGS_W - 4 * HEX0;
   localparam int HSH1 = DIGS_W - 4 * HEX1;
   localparam int HSH2 = DIGS_W - 4 * HEX2;
   localparam int DSH0 = DIGS_W - 4 * DEC0;
   localparam int DSH1 = DIGS_W - 4 * DEC1;
   localparam int DSH2 = DIGS_W - 4 * DEC2;
   // left-aligns the operand on a multiple of DAB_BITS for the BCD pass
   localparam int PSH0 = VALUE_W - DAB_BITS * HEX0;
   localparam int PSH1 = VALUE_W - DAB_BITS * HEX1;
   localparam int PSH2 = VALUE_W - DAB_BITS * HEX2;

   base_type                base_ff;
   logic [DIGS_W-1:0]       sreg_ff;
   logic [VALUE_W-1:0]      bin_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic [ITER_W-1:0]       iter_ff;
   logic [SHAMT_W-1:0]      align_ff;
   logic                    neg_ff;
   logic                    rsp_valid_ff;
   logic [CHAR_W-1:0]       rsp_char_ff;
   logic                    rsp_last_ff;

   logic [VALUE_W-1:0]      mask_sel;
   logic [POS_W-1:0]        sign_pos;
   logic [ITER_W-1:0]       iter_sel;
   logic [SHAMT_W-1:0]      pre_sh;
   logic [SHAMT_W-1:0]      align_sel;
   logic [CNT_W-1:0]        ndig_by_base [4];
   logic [SHAMT_W-1:0]      lsh_by_base  [4];

   logic [VALUE_W-1:0]      raw;
   logic                    neg_load;
   logic [VALUE_W-1:0]      abs_val;
   logic [DIGS_W-1:0]       d_sreg;
   logic [VALUE_W-1:0]      d_bin;
   logic [3:0]              top_digit;
   logic [DIGS_W-1:0]       sreg_next_digit;
   logic                    csr_wr;

   // per-width constants
   always_comb begin
      case (req_tuser[1:0])
         WSEL_16: begin
            mask_sel  = MASK0;
            sign_pos  = POS_W'(EW0 - 1);
            iter_sel  = ITER_W'(HEX0);
            pre_sh    = SHAMT_W'(PSH0);
            align_sel = SHAMT_W'(DSH0);
            ndig_by_base[BASE_BIN] = CNT_W'(EW0);
            ndig_by_base[BASE_OCT] = CNT_W'(OCT0);
            ndig_by_base[BASE_DEC] = CNT_W'(DEC0);
            ndig_by_base[BASE_HEX] = CNT_W'(HEX0);
            lsh_by_base[BASE_BIN]  = SHAMT_W'(BSH0);
            lsh_by_base[BASE_OCT]  = SHAMT_W'(OSH0);
            lsh_by_base[BASE_DEC]  = SHAMT_W'(DSH0);
            lsh_by_base[BASE_HEX]  = SHAMT_W'(HSH0);
         end
         WSEL_32: begin
            mask_sel  = MASK1;
            sign_pos  = POS_W'(EW1 - 1);
            iter_sel  = ITER_W'(HEX1);
            pre_sh    = SHAMT_W'(PSH1);
            align_sel = SHAMT_W'(DSH1);
            ndig_by_base[BASE_BIN] = CNT_W'(EW1);
            ndig_by_base[BASE_OCT] = CNT_W'(OCT1);
            ndig_by_base[BASE_DEC] = CNT_W'(DEC1);
            ndig_by_base[BASE_HEX] = CNT_W'(HEX1);
            lsh_by_base[BASE_BIN]  = SHAMT_W'(BSH1);
            lsh_by_base[BASE_OCT]  = SHAMT_W'(OSH1);
            lsh_by_base[BASE_DEC]  = SHAMT_W'(DSH1);
            lsh_by_base[BASE_HEX]  = SHAMT_W'(HSH1);
         end
         default: begin
            mask_sel  = MASK2;
            sign_pos  = POS_W'(EW2 - 1);
            iter_sel  = ITER_W'(HEX2);
            pre_sh    = SHAMT_W'(PSH2);
            align_sel = SHAMT_W'(DSH2);
            ndig_by_base[BASE_BIN] = CNT_W'(EW2);
            ndig_by_base[BASE_OCT] = CNT_W'(OCT2);
            ndig_by_base[BASE_DEC] = CNT_W'(DEC2);
            ndig_by_base[BASE_HEX] = CNT_W'(HEX2);
            lsh_by_base[BASE_BIN]  = SHAMT_W'(BSH2);
            lsh_by_base[BASE_OCT]  = SHAMT_W'(OSH2);
            lsh_by_base[BASE_DEC]  = SHAMT_W'(DSH2);
            lsh_by_base[BASE_HEX]  = SHAMT_W'(HSH2);
         end
      endcase
   end

   assign raw      = req_tdata & mask_sel;
   assign neg_load = (base_ff == BASE_DEC) && req_tuser[2] && raw[sign_pos];
   assign abs_val  = neg_load ? (VALUE_W'(0) - (raw | ~mask_sel)) : raw;

   // double dabble, DAB_BITS operand bits per cycle
   always_comb begin
      d_sreg = sreg_ff;
      d_bin  = bin_ff;
      for (int s = 0; s < DAB_BITS; s++) begin
         for (int g = 0; g < NDIGS; g++) begin
            if (d_sreg[4*g +: 4] >= 4'd5) begin
               d_sreg[4*g +: 4] = d_sreg[4*g +: 4] + 4'd3;
            end
         end
         d_sreg = {d_sreg[DIGS_W-2:0], d_bin[VALUE_W-1]};
         d_bin  = {d_bin[VALUE_W-2:0], 1'b0};
      end
   end

   always_comb begin
      case (base_ff)
         BASE_BIN: begin
            top_digit       = {3'b000, sreg_ff[DIGS_W-1]};
            sreg_next_digit = sreg_ff << 1;
         end
         BASE_OCT: begin
            top_digit       = {1'b0, sreg_ff[DIGS_W-1 -: 3]};
            sreg_next_digit = sreg_ff << 3;
         end
         default: begin
            top_digit       = sreg_ff[DIGS_W-1 -: 4];
            sreg_next_digit = sreg_ff << 4;
         end
      endcase
   end

   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_BASE);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= BASE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            base_ff <= base_type'(csr_pwdata[1:0]);
         end
         if (cmd.emit_sign || cmd.emit_digit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cnt_ff   <= ndig_by_base[base_ff];
         iter_ff  <= iter_sel;
         align_ff <= align_sel;
         neg_ff   <= neg_load;
         bin_ff   <= abs_val << pre_sh;
         if (base_ff == BASE_DEC) begin
            sreg_ff <= '0;
         end else begin
            sreg_ff <= DIGS_W'(raw) << lsh_by_base[base_ff];
         end
      end else if (cmd.dabble) begin
         sreg_ff <= d_sreg;
         bin_ff  <= d_bin;
         iter_ff <= iter_ff - ITER_W'(1);
      end else if (cmd.align) begin
         sreg_ff <= sreg_ff << align_ff;
      end else if (cmd.skip || cmd.emit_digit) begin
         sreg_ff <= sreg_next_digit;
         cnt_ff  <= cnt_ff - CNT_W'(1);
      end

      if (cmd.emit_sign) begin
         rsp_char_ff <= CHAR_MINUS;
         rsp_last_ff <= 1'b0;
      end else if (cmd.emit_digit) begin
         rsp_char_ff <= digit_glyph(top_digit);
         rsp_last_ff <= (cnt_ff == CNT_W'(1));
      end
   end

   assign status.is_dec    = (base_ff == BASE_DEC);
   assign status.neg       = neg_ff;
   assign status.top_zero  = (top_digit == 4'd0);
   assign status.cnt_one   = (cnt_ff == CNT_W'(1));
   assign status.iter_last = (iter_ff == ITER_W'(1));
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_BASE) ?
                       {{(CSR_DATA_W-2){1'b0}}, base_ff} : '0;

endmodule
`default_nettype wire

// ===== rtl/core/itoa_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Port-level checker of the integer to ASCII radix converter, bound to the top.
`include "integer_to_ascii_radix_core_defines.svh"
module itoa_chk import itoa_pkg::*; (
   input wire                   clock,
   input wire                   reset,
   input wire                   req_tvalid,
   input wire                   req_tready,
   input wire                   rsp_tvalid,
   input wire                   rsp_tready,
   input wire [RSP_DATA_W-1:0]  rsp_tdata,
   input wire                   rsp_tlast
);

   `ITOA_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast),
      "stalled result transfer changed")

   `ITOA_ASSERT_NEXT(a_one_number, req_tvalid && req_tready, !req_tready,
      "second number taken while one is in work")

   `ITOA_ASSERT_SAME(a_char_legal, rsp_tvalid,
      !rsp_tdata[7] &&
      ((rsp_tdata[6:0] >= CHAR_ZERO && rsp_tdata[6:0] <= CHAR_NINE) ||
       (rsp_tdata[6:0] >= CHAR_ALPHA && rsp_tdata[6:0] <= CHAR_HEX_F) ||
       rsp_tdata[6:0] == CHAR_MINUS),
      "character is not a digit or minus sign")

   `ITOA_ASSERT_SAME(a_minus_not_last, rsp_tvalid && rsp_tdata[6:0] == CHAR_MINUS,
      !rsp_tlast, "minus sign flagged as last character")

endmodule

bind integer_to_ascii_radix_core itoa_chk u_itoa_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
